[design/srr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srr_pkg: shared types and constants
// Shared by the selective repeat receiver modules: codes, fill values,
// result record and controller states.
// ----------------------------------------------------------------------------
package srr_pkg;

    localparam int PAY_BYTES   = 20;
    localparam int PAY_W       = 8 * PAY_BYTES;
    localparam int SEQ_FW      = 4;
    localparam int CHECK_FW    = 10;
    localparam int MAX_DELIVER = 6;
    localparam int CNT_W       = $clog2(MAX_DELIVER);

    localparam logic [7:0]          ZERO_CHAR      = 8'h30;
    localparam logic [63:0]         ACK_FILL64     = {8{ZERO_CHAR}};
    localparam logic [31:0]         ACK_FILL32     = {4{ZERO_CHAR}};
    localparam logic [CHECK_FW-1:0] ACK_CHECK_BASE = CHECK_FW'(PAY_BYTES * 48);

    localparam logic KIND_ACK = 1'b0;
    localparam logic KIND_DLV = 1'b1;

    typedef struct packed {
        logic                kind;
        logic                ack_seq_bit;
        logic [SEQ_FW-1:0]   ack_of;
        logic [CHECK_FW-1:0] ack_check;
        logic [63:0]         out_low;
        logic [63:0]         out_mid;
        logic [31:0]         out_high;
        logic                last;
    } srr_res_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_ADD,
        ST_CMP,
        ST_DECIDE,
        ST_ACK,
        ST_RD,
        ST_DLV
    } srr_state_t;

endpackage
`default_nettype wire

[design/srr_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srr_in_if: packet channel
// Valid/ready channel that carries one received packet per item.
// ----------------------------------------------------------------------------
interface srr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] seq_num;
    logic signed [31:0] ack_num;
    logic signed [31:0] check_value;
    logic [63:0]        data_low;
    logic [63:0]        data_mid;
    logic [31:0]        data_high;

    modport source (
        output valid, seq_num, ack_num, check_value, data_low, data_mid, data_high,
        input  ready
    );
    modport sink (
        input  valid, seq_num, ack_num, check_value, data_low, data_mid, data_high,
        output ready
    );
endinterface
`default_nettype wire

[design/srr_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srr_out_if: result channel
// Valid/ready channel that carries one ACK or one delivery per item.
// ----------------------------------------------------------------------------
interface srr_out_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic        ack_seq_bit;
    logic [3:0]  ack_of;
    logic [9:0]  ack_check;
    logic [63:0] out_low;
    logic [63:0] out_mid;
    logic [31:0] out_high;
    logic        last;

    modport source (
        output valid, kind, ack_seq_bit, ack_of, ack_check, out_low, out_mid,
               out_high, last,
        input  ready
    );
    modport sink (
        input  valid, kind, ack_seq_bit, ack_of, ack_check, out_low, out_mid,
               out_high, last,
        output ready
    );
endinterface
`default_nettype wire

[design/srr_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srr_ram: generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module srr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

[design/srr_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// srr_chk: packet checksum pipeline
// Three stages: byte group sums with the header sum, group total, final compare.
// ----------------------------------------------------------------------------
module srr_chk
    import srr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic [31:0]        seq_num,
    input  wire logic [31:0]        ack_num,
    input  wire logic [31:0]        check_value,
    input  wire logic [PAY_W-1:0]   payload,
    output logic                    good
);

    localparam int GRP_N = PAY_BYTES / 4;
    localparam int TOT_W = 13;

    function automatic logic [9:0] sext_byte(input logic [7:0] b);
        return {{2{b[7]}}, b};
    endfunction

    logic [9:0]       grp_next [GRP_N];
    logic [9:0]       grp_reg  [GRP_N];
    logic [TOT_W-1:0] tot_next;
    logic [TOT_W-1:0] tot_reg;
    logic [31:0]      hdr_reg;

    // lane sums of four signed bytes each
    always_comb
    begin
        for (int g = 0; g < GRP_N; g++)
        begin
            grp_next[g] = sext_byte(payload[32*g +: 8])
                        + sext_byte(payload[32*g+8 +: 8])
                        + sext_byte(payload[32*g+16 +: 8])
                        + sext_byte(payload[32*g+24 +: 8]);
        end
    end

    always_comb
    begin
        tot_next = '0;
        for (int g = 0; g < GRP_N; g++)
        begin
            tot_next = tot_next + {{(TOT_W-10){grp_reg[g][9]}}, grp_reg[g]};
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
        tot_reg <= tot_next;
        hdr_reg <= seq_num + ack_num;
        good    <= (hdr_reg + {{(32-TOT_W){tot_reg[TOT_W-1]}}, tot_reg}) == check_value;
    end

endmodule
`default_nettype wire

[design/selective_repeat_receiver_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// selective_repeat_receiver_top: selective repeat ARQ receiver
// Checks each packet, buffers in-window payloads and emits an ACK followed
// by in-order deliveries of buffered payloads.
// ----------------------------------------------------------------------------
// The ACK is loaded into the output register in ST_ACK, after ST_SUM, ST_ADD,
// ST_CMP and ST_DECIDE; it waits in ST_ACK while the output is not free. Each
// delivery is a payload RAM read, then an output load, at most 6 deliveries a packet.
// A corrupted or out-of-range packet returns to idle from ST_DECIDE; no new packet is taken before idle.
// Reset clears the slot marks, expected sequence and output valid at once and
// sets the ACK bit; the payload RAM is not cleared.
module selective_repeat_receiver_top
    import srr_pkg::*;
#(
    parameter int SEQ_SPACE   = 12,
    parameter int WINDOW_SIZE = 6
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    srr_in_if.sink     pkt,
    srr_out_if.source  res
);

    localparam int IDX_W = $clog2(SEQ_SPACE);
    localparam int DW    = IDX_W + 1;

    // held packet (payload registers, loaded on accept)
    logic [31:0]      seq_reg;
    logic [31:0]      ack_reg;
    logic [31:0]      chkv_reg;
    logic [PAY_W-1:0] pay_reg;

    // receiver state
    srr_state_t           state_reg, state_next;
    logic [IDX_W-1:0]     exp_seq_reg, exp_seq_next;
    logic                 ack_bit_reg, ack_bit_next;
    logic [SEQ_SPACE-1:0] marks_reg, marks_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 out_valid_reg, out_valid_next;
    srr_res_t             out_reg, out_next;

    // control strobes
    logic pkt_take;
    logic out_free;
    logic out_load;
    logic store;
    logic ram_re;

    logic             good;
    logic [PAY_W-1:0] ram_rdata;
    logic [IDX_W-1:0] seq_idx;
    logic             seq_ok;
    logic [DW-1:0]    dist_raw;
    logic [DW-1:0]    slot_off;
    logic             in_window;
    logic [IDX_W-1:0] exp_inc;
    logic [DW-1:0]    exp_wide;
    logic             dlv_last;

    // ------------------------------------------------------------------
    // Checksum pipeline and payload RAM
    // ------------------------------------------------------------------
    srr_chk u_chk (
        .clk         (clk),
        .seq_num     (seq_reg),
        .ack_num     (ack_reg),
        .check_value (chkv_reg),
        .payload     (pay_reg),
        .good        (good)
    );

    srr_ram #(
        .WIDTH (PAY_W),
        .DEPTH (SEQ_SPACE)
    ) u_pay_ram (
        .clk     (clk),
        .wr_en   (store),
        .wr_addr (seq_idx),
        .wr_data (pay_reg),
        .rd_en   (ram_re),
        .rd_addr (exp_seq_reg),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Sequence arithmetic
    // ------------------------------------------------------------------
    assign seq_ok  = seq_reg < 32'(SEQ_SPACE);
    assign seq_idx = seq_reg[IDX_W-1:0];

    // distance from the expected slot, modulo the sequence space
    assign dist_raw  = {1'b0, seq_idx} + DW'(SEQ_SPACE) - {1'b0, exp_seq_reg};
    assign slot_off  = (dist_raw >= DW'(SEQ_SPACE)) ? dist_raw - DW'(SEQ_SPACE) : dist_raw;
    assign in_window = {{(32-DW){1'b0}}, slot_off} < 32'(WINDOW_SIZE);

    // next expected slot, wrapping at the end of the sequence space
    assign exp_wide = {1'b0, exp_seq_reg} + DW'(1);
    assign exp_inc  = (exp_wide == DW'(SEQ_SPACE)) ? '0 : exp_wide[IDX_W-1:0];

    // stop after the delivery bound or when the following slot is empty
    assign dlv_last = (cnt_reg == CNT_W'(MAX_DELIVER - 1)) || !marks_reg[exp_inc];

    assign out_free = !out_valid_reg || res.ready;
    assign pkt_take = pkt.valid && pkt.ready;

    // ------------------------------------------------------------------
    // Controller: next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (pkt.valid) state_next = ST_SUM;
            ST_SUM:    state_next = ST_ADD;
            ST_ADD:    state_next = ST_CMP;
            ST_CMP:    state_next = ST_DECIDE;
            ST_DECIDE: state_next = (good && seq_ok) ? ST_ACK : ST_IDLE;
            ST_ACK:
            begin
                if (out_free)
                begin
                    state_next = marks_reg[exp_seq_reg] ? ST_RD : ST_IDLE;
                end
            end
            ST_RD:     state_next = ST_DLV;
            ST_DLV:
            begin
                if (out_free)
                begin
                    state_next = dlv_last ? ST_IDLE : ST_RD;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Controller: strobes
    // ------------------------------------------------------------------
    always_comb
    begin
        pkt.ready = 1'b0;
        out_load  = 1'b0;
        store     = 1'b0;
        ram_re    = 1'b0;
        unique case (state_reg)
            ST_IDLE:   pkt.ready = 1'b1;
            ST_DECIDE: store = good && seq_ok && in_window && !marks_reg[seq_idx];
            ST_ACK:    out_load = out_free;
            ST_RD:     ram_re = 1'b1;
            ST_DLV:    out_load = out_free;
            ST_SUM, ST_ADD, ST_CMP: ;
            default:   ;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        exp_seq_next   = exp_seq_reg;
        ack_bit_next   = ack_bit_reg;
        marks_next     = marks_reg;
        cnt_next       = cnt_reg;
        out_next       = out_reg;
        out_valid_next = out_load ? 1'b1 : (res.ready ? 1'b0 : out_valid_reg);

        // mark the slot that takes this payload
        if (store)
        begin
            marks_next[seq_idx] = 1'b1;
        end

        if (out_load && state_reg == ST_ACK)
        begin
            out_next.kind        = KIND_ACK;
            out_next.ack_seq_bit = ack_bit_reg;
            out_next.ack_of      = SEQ_FW'(seq_idx);
            out_next.ack_check   = ACK_CHECK_BASE + CHECK_FW'(ack_bit_reg)
                                 + CHECK_FW'(seq_idx);
            out_next.out_low     = ACK_FILL64;
            out_next.out_mid     = ACK_FILL64;
            out_next.out_high    = ACK_FILL32;
            out_next.last        = !marks_reg[exp_seq_reg];
            ack_bit_next         = !ack_bit_reg;
            cnt_next             = '0;
        end

        // deliver the expected slot, release it and advance
        if (out_load && state_reg == ST_DLV)
        begin
            out_next.kind        = KIND_DLV;
            out_next.ack_seq_bit = 1'b0;
            out_next.ack_of      = '0;
            out_next.ack_check   = '0;
            out_next.out_low     = ram_rdata[63:0];
            out_next.out_mid     = ram_rdata[127:64];
            out_next.out_high    = ram_rdata[159:128];
            out_next.last        = dlv_last;
            marks_next[exp_seq_reg] = 1'b0;
            exp_seq_next         = exp_inc;
            cnt_next             = cnt_reg + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            exp_seq_reg   <= '0;
            ack_bit_reg   <= 1'b1;
            marks_reg     <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            exp_seq_reg   <= exp_seq_next;
            ack_bit_reg   <= ack_bit_next;
            marks_reg     <= marks_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold the packet while it is checked and answered
    always_ff @(posedge clk)
    begin
        if (pkt_take)
        begin
            seq_reg  <= pkt.seq_num;
            ack_reg  <= pkt.ack_num;
            chkv_reg <= pkt.check_value;
            pay_reg  <= {pkt.data_high, pkt.data_mid, pkt.data_low};
        end
        out_reg <= out_next;
    end

    assign res.valid       = out_valid_reg;
    assign res.kind        = out_reg.kind;
    assign res.ack_seq_bit = out_reg.ack_seq_bit;
    assign res.ack_of      = out_reg.ack_of;
    assign res.ack_check   = out_reg.ack_check;
    assign res.out_low     = out_reg.out_low;
    assign res.out_mid     = out_reg.out_mid;
    assign res.out_high    = out_reg.out_high;
    assign res.last        = out_reg.last;

`ifndef SYNTHESIS
    // the expected slot never leaves the sequence space
    a_exp_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(exp_seq_reg) < SEQ_SPACE)
        else $error("expected sequence out of range");

    // a delivery only comes from a marked slot
    a_dlv_marked: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg == ST_DLV) |-> marks_reg[exp_seq_reg])
        else $error("delivery from an unmarked slot");

    // a payload is never written over a marked slot
    a_store_free: assert property (@(posedge clk) disable iff (!rst_n)
        store |-> !marks_reg[seq_idx])
        else $error("store over a marked slot");

    // the final result of a packet returns the controller to idle
    a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && out_next.last) |=> state_reg == ST_IDLE)
        else $error("last result without return to idle");

    // the ACK bit toggles exactly when an ACK is loaded
    a_ack_toggle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && state_reg == ST_ACK) |=> ack_bit_reg != $past(ack_bit_reg))
        else $error("ACK bit did not toggle");
`endif

endmodule
`default_nettype wire
